// ----- rtl/core/lldeq_pkg.sv -----
// ----------------------------------------------------------------------------
// Least-loaded dispatch package
// Shared widths, codes, state encoding and record types of the dispatcher.
// ----------------------------------------------------------------------------
package lldeq_pkg;

  localparam int MAX_MACHINES_DEF = 16;
  localparam int LOAD_W           = 24;
  localparam int JOB_W            = 16;
  localparam int CFG_W            = 5;
  localparam int CHOSEN_W         = 4;

  localparam logic [CFG_W-1:0]  CFG_RESET = 5'd4;
  localparam logic [LOAD_W-1:0] LOAD_MAX  = {LOAD_W{1'b1}};

  localparam logic OP_ASSIGN = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [LOAD_W-1:0] load;
    logic [JOB_W-1:0]  small_job;
  } entry_t;

  typedef struct packed {
    logic [CHOSEN_W-1:0] chosen;
    logic [LOAD_W-1:0]   new_load;
    logic                is_eq;
  } res_t;

endpackage

// ----- rtl/core/lldeq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lldeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/lldeq_engine.sv -----
// ----------------------------------------------------------------------------
// Dispatch engine
// Sequencer that scans the machine table for the least load, writes back the
// chosen entry and scans again for the stability check.
// ----------------------------------------------------------------------------
module lldeq_engine #(
  parameter int MAX_MACHINES = lldeq_pkg::MAX_MACHINES_DEF,
  localparam int IW = $clog2(MAX_MACHINES),
  localparam int CW = $clog2(MAX_MACHINES + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         op,
  input  logic [lldeq_pkg::JOB_W-1:0]  job_time,
  input  logic [lldeq_pkg::CFG_W-1:0]  machines_in_use,
  output logic                         busy,
  output logic                         res_valid,
  input  logic                         res_take,
  output lldeq_pkg::res_t              res,
  output logic                         ram_we,
  output logic [IW-1:0]                ram_waddr,
  output lldeq_pkg::entry_t            ram_wdata,
  output logic                         ram_re,
  output logic [IW-1:0]                ram_raddr,
  input  lldeq_pkg::entry_t            ram_rdata
);

  localparam int LW = lldeq_pkg::LOAD_W;
  localparam int JW = lldeq_pkg::JOB_W;
  localparam logic [LW:0] SENT = {1'b1, {LW{1'b0}}};

  lldeq_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           n_r, n_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]           rd_idx_r, rd_idx_nxt;
  logic [JW-1:0]           t_r, t_nxt;
  logic [LW:0]             m1_r, m1_nxt, m2_r, m2_nxt, m3_r, m3_nxt;
  logic [IW-1:0]           idx1_r, idx1_nxt, idx2_r, idx2_nxt;
  logic [JW-1:0]           s1_r, s1_nxt;
  logic [LW:0]             lo1_r, lo1_nxt, lo2_r, lo2_nxt;
  logic [IW-1:0]           lo1idx_r, lo1idx_nxt;
  logic                    unst_r, unst_nxt;
  logic [MAX_MACHINES-1:0] holds_r, holds_nxt;
  logic [lldeq_pkg::CHOSEN_W-1:0] chosen_r, chosen_nxt;
  logic [LW-1:0]           load_r, load_nxt;

  logic [CW-1:0]           n_act;
  logic                    rd_holds;
  logic [LW:0]             v;
  logic [JW-1:0]           sv;
  logic [LW:0]             sum_w;
  logic [LW-1:0]           sat;
  logic [JW-1:0]           snew;
  logic [LW:0]             low;
  logic [LW+1:0]           bound;
  logic [IW+3:0]           idx_ext;

  always_comb begin
    if (machines_in_use == '0) begin
      n_act = CW'(1);
    end else if (32'(machines_in_use) > MAX_MACHINES) begin
      n_act = CW'(MAX_MACHINES);
    end else begin
      n_act = CW'(machines_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lldeq_pkg::ST_IDLE;
      holds_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      holds_r  <= holds_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    n_r      <= n_nxt;
    rd_idx_r <= rd_idx_nxt;
    t_r      <= t_nxt;
    m1_r     <= m1_nxt;
    m2_r     <= m2_nxt;
    m3_r     <= m3_nxt;
    idx1_r   <= idx1_nxt;
    idx2_r   <= idx2_nxt;
    s1_r     <= s1_nxt;
    lo1_r    <= lo1_nxt;
    lo2_r    <= lo2_nxt;
    lo1idx_r <= lo1idx_nxt;
    unst_r   <= unst_nxt;
    chosen_r <= chosen_nxt;
    load_r   <= load_nxt;
  end

  always_comb begin
    rd_holds = holds_r[rd_idx_r];
    v        = rd_holds ? {1'b0, ram_rdata.load} : '0;
    sv       = rd_holds ? ram_rdata.small_job : '0;
    sum_w    = {1'b0, m1_r[LW-1:0]} + (LW+1)'(t_r);
    sat      = sum_w[LW] ? lldeq_pkg::LOAD_MAX : sum_w[LW-1:0];
    snew     = (!holds_r[idx1_r] || (t_r < s1_r)) ? t_r : s1_r;
    low      = (rd_idx_r == lo1idx_r) ? lo2_r : lo1_r;
    bound    = {1'b0, low} + (LW+2)'(ram_rdata.small_job);
    idx_ext  = {4'b0000, idx1_r};
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    n_nxt      = n_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    t_nxt      = t_r;
    m1_nxt     = m1_r;
    m2_nxt     = m2_r;
    m3_nxt     = m3_r;
    idx1_nxt   = idx1_r;
    idx2_nxt   = idx2_r;
    s1_nxt     = s1_r;
    lo1_nxt    = lo1_r;
    lo2_nxt    = lo2_r;
    lo1idx_nxt = lo1idx_r;
    unst_nxt   = unst_r;
    holds_nxt  = holds_r;
    chosen_nxt = chosen_r;
    load_nxt   = load_r;
    busy       = 1'b1;
    res_valid  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx1_r;
    ram_wdata  = '{load: sat, small_job: snew};
    ram_re     = 1'b0;
    ram_raddr  = cnt_r[IW-1:0];

    case (state_r)
      lldeq_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (op == lldeq_pkg::OP_CLEAR) begin
            holds_nxt  = '0;
            chosen_nxt = '0;
            load_nxt   = '0;
            unst_nxt   = 1'b0;
            state_nxt  = lldeq_pkg::ST_DONE;
          end else begin
            n_nxt     = n_act;
            t_nxt     = job_time;
            cnt_nxt   = '0;
            m1_nxt    = SENT;
            m2_nxt    = SENT;
            m3_nxt    = SENT;
            idx1_nxt  = '0;
            idx2_nxt  = '0;
            s1_nxt    = '0;
            state_nxt = lldeq_pkg::ST_SCAN;
          end
        end
      end

      lldeq_pkg::ST_SCAN: begin
        if (cnt_r < n_r) begin
          ram_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = cnt_r[IW-1:0];
          cnt_nxt    = cnt_r + CW'(1);
        end else begin
          state_nxt = lldeq_pkg::ST_WRITE;
        end
        if (rd_vld_r) begin
          if (v < m1_r) begin
            m3_nxt   = m2_r;
            m2_nxt   = m1_r;
            idx2_nxt = idx1_r;
            m1_nxt   = v;
            idx1_nxt = rd_idx_r;
            s1_nxt   = sv;
          end else if (v < m2_r) begin
            m3_nxt   = m2_r;
            m2_nxt   = v;
            idx2_nxt = rd_idx_r;
          end else if (v < m3_r) begin
            m3_nxt = v;
          end
        end
      end

      lldeq_pkg::ST_WRITE: begin
        ram_we            = 1'b1;
        holds_nxt[idx1_r] = 1'b1;
        chosen_nxt        = idx_ext[3:0];
        load_nxt          = sat;
        unst_nxt          = 1'b0;
        cnt_nxt           = '0;
        if ({1'b0, sat} < m2_r) begin
          lo1_nxt    = {1'b0, sat};
          lo1idx_nxt = idx1_r;
          lo2_nxt    = m2_r;
        end else begin
          lo1_nxt    = m2_r;
          lo1idx_nxt = idx2_r;
          lo2_nxt    = ({1'b0, sat} < m3_r) ? {1'b0, sat} : m3_r;
        end
        state_nxt = lldeq_pkg::ST_CHECK;
      end

      lldeq_pkg::ST_CHECK: begin
        if (cnt_r < n_r) begin
          ram_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = cnt_r[IW-1:0];
          cnt_nxt    = cnt_r + CW'(1);
        end else begin
          state_nxt = lldeq_pkg::ST_DONE;
        end
        if (rd_vld_r && rd_holds && ({2'b00, ram_rdata.load} > bound)) begin
          unst_nxt = 1'b1;
        end
      end

      lldeq_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = lldeq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lldeq_pkg::ST_IDLE;
      end
    endcase
  end

  assign res = '{chosen: chosen_r, new_load: load_r, is_eq: ~unst_r};

endmodule

// ----- rtl/core/least_loaded_dispatch_with_equilibrium.sv -----
// ----------------------------------------------------------------------------
// Least-loaded dispatch with equilibrium check
// Places each job on the least-loaded machine in use and reports stability.
// ----------------------------------------------------------------------------
// An assign request runs one pass over the machine table entries in use for
// the least-load search, a write-back step and a second pass over the same
// single-read-port memory for the stability check before the next request
// can be accepted. A clear request only resets the per-machine occupancy
// flags and the result fields. A new request is accepted whilst a finished
// result waits in the output register. Machine count changes must be written
// only whilst idle by the user; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module least_loaded_dispatch_with_equilibrium #(
  parameter int MAX_MACHINES = lldeq_pkg::MAX_MACHINES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lldeq_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [lldeq_pkg::JOB_W-1:0]     in_job_time,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lldeq_pkg::CHOSEN_W-1:0]  out_chosen_machine,
  output logic [lldeq_pkg::LOAD_W-1:0]    out_new_load,
  output logic                            out_is_equilibrium
);

  localparam int IW = $clog2(MAX_MACHINES);

  logic [lldeq_pkg::CFG_W-1:0] mu_r;
  logic                        out_valid_r;
  lldeq_pkg::res_t             out_r;
  logic                        accept;
  logic                        eng_busy;
  logic                        eng_res_valid;
  logic                        eng_res_take;
  lldeq_pkg::res_t             eng_res;
  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  lldeq_pkg::entry_t           ram_wdata;
  logic                        ram_re;
  logic [IW-1:0]               ram_raddr;
  lldeq_pkg::entry_t           ram_rdata;

  assign accept       = in_valid && !in_stall;
  assign in_stall     = eng_busy;
  assign eng_res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r <= lldeq_pkg::CFG_RESET;
    end else if (cfg_we) begin
      mu_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_res_valid && eng_res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_valid && eng_res_take) begin
      out_r <= eng_res;
    end
  end

  lldeq_ram #(
    .WIDTH ($bits(lldeq_pkg::entry_t)),
    .DEPTH (MAX_MACHINES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lldeq_engine #(
    .MAX_MACHINES (MAX_MACHINES)
  ) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (accept),
    .op              (in_operation),
    .job_time        (in_job_time),
    .machines_in_use (mu_r),
    .busy            (eng_busy),
    .res_valid       (eng_res_valid),
    .res_take        (eng_res_take),
    .res             (eng_res),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_chosen_machine = out_r.chosen;
  assign out_new_load       = out_r.new_load;
  assign out_is_equilibrium = out_r.is_eq;

  // An accepted request always keeps the engine busy for the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("engine free directly after accepting a request");

  // A pending result means no further request can be taken.
  a_result_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    eng_res_valid |-> in_stall)
    else $error("request accepted whilst a result is pending");

  // A result handed over always appears in the output register.
  a_handover: assert property (@(posedge clk) disable iff (!rst_n)
    (eng_res_valid && eng_res_take) |=> (out_valid && out_r == $past(eng_res)))
    else $error("result lost on handover to the output register");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench of the least-loaded dispatcher with equilibrium check
// Sends assign and clear requests under random idling on both channels and
// checks every result against a cycle-free model of the machine table that
// also tracks the machine count register.
// ----------------------------------------------------------------------------
module tb;

  localparam int NUM_M = lldeq_pkg::MAX_MACHINES_DEF;

  class dispatch_checker;
    logic [lldeq_pkg::LOAD_W-1:0] load_of [NUM_M];
    logic [lldeq_pkg::JOB_W-1:0]  min_job [NUM_M];
    bit                           busy    [NUM_M];
    logic [lldeq_pkg::CFG_W-1:0]  machine_cnt;
    lldeq_pkg::res_t              pending_results [$];
    int                           mismatches;

    function new();
      clear_machines();
      machine_cnt = lldeq_pkg::CFG_RESET;
      mismatches  = 0;
    endfunction

    function void clear_machines();
      for (int m = 0; m < NUM_M; m++) begin
        load_of[m] = '0;
        min_job[m] = '0;
        busy[m]    = 1'b0;
      end
    endfunction

    function void set_machine_count(logic [lldeq_pkg::CFG_W-1:0] value);
      machine_cnt = value;
    endfunction

    function int active_machines();
      if (machine_cnt == 0) return 1;
      if (machine_cnt > NUM_M) return NUM_M;
      return int'(machine_cnt);
    endfunction

    function bit all_stable(int n);
      logic [lldeq_pkg::LOAD_W-1:0] lowest;
      for (int m = 0; m < n; m++) begin
        if (!busy[m] || n < 2) continue;
        lowest = lldeq_pkg::LOAD_MAX;
        for (int k = 0; k < n; k++) begin
          if (k != m && load_of[k] < lowest) lowest = load_of[k];
        end
        if (load_of[m] > lowest &&
            load_of[m] - lowest > (lldeq_pkg::LOAD_W)'(min_job[m])) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Works out the outcome of one accepted request and queues it.
    function void note_request(logic op, logic [lldeq_pkg::JOB_W-1:0] job);
      int                         n;
      int                         best;
      logic [lldeq_pkg::LOAD_W:0] sum;
      lldeq_pkg::res_t            r;
      n = active_machines();
      if (op == lldeq_pkg::OP_CLEAR) begin
        clear_machines();
        r.chosen   = '0;
        r.new_load = '0;
        r.is_eq    = 1'b1;
      end else begin
        best = 0;
        for (int m = 1; m < n; m++) begin
          if (load_of[m] < load_of[best]) best = m;
        end
        sum = {1'b0, load_of[best]} + (lldeq_pkg::LOAD_W + 1)'(job);
        if (sum > {1'b0, lldeq_pkg::LOAD_MAX}) sum = {1'b0, lldeq_pkg::LOAD_MAX};
        load_of[best] = sum[lldeq_pkg::LOAD_W-1:0];
        if (!busy[best] || job < min_job[best]) min_job[best] = job;
        busy[best] = 1'b1;
        r.chosen   = (lldeq_pkg::CHOSEN_W)'(best);
        r.new_load = sum[lldeq_pkg::LOAD_W-1:0];
        r.is_eq    = all_stable(n);
      end
      pending_results = {pending_results, r};
    endfunction

    task report(string msg);
      if (mismatches < 50) $display("%0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [lldeq_pkg::CHOSEN_W-1:0] chosen,
                      logic [lldeq_pkg::LOAD_W-1:0] new_load, logic is_eq);
      lldeq_pkg::res_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result, machine %0d load %0d", chosen, new_load));
        return;
      end
      want = pending_results.pop_front();
      if (chosen !== want.chosen)
        report($sformatf("chosen_machine got %0d, expected %0d", chosen, want.chosen));
      if (new_load !== want.new_load)
        report($sformatf("new_load got %0d, expected %0d", new_load, want.new_load));
      if (is_eq !== want.is_eq)
        report($sformatf("is_equilibrium got %0d, expected %0d", is_eq, want.is_eq));
    endtask
  endclass

  logic                           clk          = 1'b0;
  logic                           rst_n        = 1'b0;
  logic                           cfg_we       = 1'b0;
  logic [lldeq_pkg::CFG_W-1:0]    cfg_wdata    = '0;
  logic                           in_valid     = 1'b0;
  logic                           in_operation = lldeq_pkg::OP_ASSIGN;
  logic [lldeq_pkg::JOB_W-1:0]    in_job_time  = '0;
  logic                           out_stall    = 1'b0;
  logic                           in_stall;
  logic                           out_valid;
  logic [lldeq_pkg::CHOSEN_W-1:0] out_chosen_machine;
  logic [lldeq_pkg::LOAD_W-1:0]   out_new_load;
  logic                           out_is_equilibrium;

  dispatch_checker sb;
  bit              hold_request = 1'b0;
  int              random_items;

  least_loaded_dispatch_with_equilibrium i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_job_time        (in_job_time),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_chosen_machine (out_chosen_machine),
    .out_new_load       (out_new_load),
    .out_is_equilibrium (out_is_equilibrium)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap(int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [lldeq_pkg::JOB_W-1:0] pick_job(int mode);
    case (mode)
      0: return (lldeq_pkg::JOB_W)'($urandom_range(0, 65535));
      1: return (lldeq_pkg::JOB_W)'($urandom_range(0, 15));
      2: begin
        if ($urandom_range(0, 1) == 0) return (lldeq_pkg::JOB_W)'($urandom_range(200, 1000));
        return (lldeq_pkg::JOB_W)'($urandom_range(1, 20));
      end
      default: return '1;
    endcase
  endfunction

  task automatic send_request(logic op, logic [lldeq_pkg::JOB_W-1:0] job, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_job_time  <= job;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, job);
  endtask

  task automatic wait_idle();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_config(logic [lldeq_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_machine_count(value);
  endtask

  task automatic run_phase(logic [lldeq_pkg::CFG_W-1:0] count_cfg, int n_req,
                           int job_mode, int gap_mode, int clear_pct, bit squeeze);
    logic op;
    wait_idle();
    write_config(count_cfg);
    if (squeeze) hold_request = 1'b1;
    for (int i = 0; i < n_req; i++) begin
      op = ($urandom_range(0, 99) < clear_pct) ? lldeq_pkg::OP_CLEAR
                                               : lldeq_pkg::OP_ASSIGN;
      send_request(op, pick_job(job_mode), pick_gap(gap_mode));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int hold_left;
    int seg_left;
    bit seg_stall;
    hold_left = 0;
    seg_left  = 0;
    seg_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_chosen_machine, out_new_load, out_is_equilibrium);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_stall = !seg_stall;
          if (seg_stall) begin
            seg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                   : $urandom_range(1, 3);
          end else begin
            seg_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 4);
          end
        end
        seg_left--;
        out_stall <= seg_stall;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Four machines from reset: field extremes, clears, and a sequence that
    // leaves a machine whose small job would gain by moving.
    send_request(lldeq_pkg::OP_ASSIGN, 16'h0000, 0);
    send_request(lldeq_pkg::OP_ASSIGN, 16'hFFFF, 0);
    send_request(lldeq_pkg::OP_ASSIGN, 16'h0001, 1);
    send_request(lldeq_pkg::OP_ASSIGN, 16'h8000, 0);
    send_request(lldeq_pkg::OP_ASSIGN, 16'h5555, 2);
    send_request(lldeq_pkg::OP_ASSIGN, 16'hAAAA, 0);
    send_request(lldeq_pkg::OP_CLEAR,  16'h1234, 0);
    send_request(lldeq_pkg::OP_ASSIGN, 16'd5, 0);
    send_request(lldeq_pkg::OP_ASSIGN, 16'd5, 0);
    send_request(lldeq_pkg::OP_ASSIGN, 16'd5, 0);
    send_request(lldeq_pkg::OP_ASSIGN, 16'd5, 0);
    send_request(lldeq_pkg::OP_ASSIGN, 16'd1, 0);
    send_request(lldeq_pkg::OP_ASSIGN, 16'd100, 0);
    send_request(lldeq_pkg::OP_CLEAR,  16'hFFFF, 0);
    in_valid <= 1'b0;

    run_phase(5'd1, 4, 2, 1, 0, 1'b0);
    run_phase(5'd0, 3, 2, 1, 0, 1'b0);
    run_phase(5'd16, 20, 2, 1, 0, 1'b0);
    run_phase(5'd31, 8, 1, 1, 0, 1'b0);
    run_phase(5'd17, 6, 0, 1, 0, 1'b0);
    run_phase(5'd2, 8, 2, 0, 10, 1'b0);
    run_phase(5'd1, 270, 3, 0, 0, 1'b0);
    run_phase(5'd16, 40, 2, 0, 5, 1'b1);

    random_items = 0;
    while (random_items < 130) begin
      int n_req;
      n_req = $urandom_range(10, 50);
      run_phase(($urandom_range(0, 9) == 0) ? (lldeq_pkg::CFG_W)'($urandom_range(17, 31))
                                            : (lldeq_pkg::CFG_W)'($urandom_range(0, 16)),
                n_req, $urandom_range(0, 2), $urandom_range(0, 1),
                $urandom_range(0, 5), 1'b0);
      random_items += n_req;
    end

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
